// ===== hdl/ssd_pkg.sv =====
// Shared types, constants and codes for the stereo sweep delay block.
`timescale 1ns / 1ps

package ssd_pkg;

    // History ring size in interleaved entries (left even, right odd).
    localparam int RING_ENTRIES = 131072;
    localparam int FRAME_DEPTH  = RING_ENTRIES / 2;
    localparam int RING_FW      = $clog2(FRAME_DEPTH);

    localparam int SAMPLE_W  = 16;
    localparam int DELAY_W   = 17;
    localparam int GAIN_W    = 16;
    localparam int PAN_W     = 8;
    localparam int LANES     = 2;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_ENTRIES = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_GAIN    = 8'd1;

    localparam logic signed [PAN_W-1:0] PAN_SPAN = 8'sd100;

    // Tap scaling: round(p / (200 * 65535)). The divisor is 8 * TAP_E, so the
    // rounded numerator is shifted down by three and divided by TAP_E through
    // a reciprocal estimate and one correction step.
    localparam logic [37:0] TAP_HALF  = 38'd6553500;
    localparam logic [20:0] TAP_E     = 21'd1638375;
    localparam logic [24:0] TAP_RECIP = 25'((64'd1 << 45) / 64'(TAP_E));

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
        logic                       block_end;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } out_t;

    typedef struct packed {
        logic accept;
        logic stage1;
        logic stage2;
        logic stage3;
        logic stage4;
        logic finish;
    } ctrl_cmd_t;

endpackage

// ===== hdl/ssd_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module ssd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/ssd_ctrl.sv =====
// Sequencing state machine for the stereo sweep delay block.
`timescale 1ns / 1ps

module ssd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output ssd_pkg::ctrl_cmd_t cmd
);
    import ssd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL1 = 3'd1;
    localparam logic [2:0] ST_MUL2 = 3'd2;
    localparam logic [2:0] ST_MUL3 = 3'd3;
    localparam logic [2:0] ST_MUL4 = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                cmd.stage1 = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.stage2 = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                cmd.stage3 = 1'b1;
                state_next = ST_MUL4;
            end
            ST_MUL4: begin
                cmd.stage4 = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hold the finished frame until the output register can take it.
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hdl/ssd_datapath.sv =====
// Datapath: history ring, tap scaling, saturation, pan sweep and config registers.
`timescale 1ns / 1ps

module ssd_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ssd_pkg::ctrl_cmd_t                  cmd,
    input  logic                                cfg_valid,
    input  logic [ssd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ssd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  ssd_pkg::in_t                        s_data,
    output ssd_pkg::out_t                       m_data
);
    import ssd_pkg::*;

    // Configuration and control state.
    logic [DELAY_W-1:0]        delay_entries_reg;
    logic [DELAY_W-1:0]        delay_entries_next;
    logic [GAIN_W-1:0]         delay_gain_reg;
    logic [GAIN_W-1:0]         delay_gain_next;
    logic [RING_FW-1:0]        wp_reg;
    logic [RING_FW-1:0]        wp_next;
    logic                      wrapped_reg;
    logic                      wrapped_next;
    logic signed [PAN_W-1:0]   pan_count_reg;
    logic signed [PAN_W-1:0]   pan_count_next;
    logic                      pan_falling_reg;
    logic                      pan_falling_next;

    // Frame payload.
    logic signed [SAMPLE_W-1:0] in_left_reg;
    logic signed [SAMPLE_W-1:0] in_right_reg;
    logic                       in_end_reg;
    logic                       hit_reg;
    out_t                       out_reg;

    // Ring addressing.
    logic [31:0]               rd_diff;
    logic [RING_FW-1:0]        rd_frame;
    logic                      rd_hit;
    logic [SAMPLE_W-1:0]       ram_rdata [LANES];

    // Per-lane tap arithmetic (lane 0 left, lane 1 right).
    logic signed [SAMPLE_W-1:0] tap_sample [LANES];
    logic signed [PAN_W-1:0]    weight     [LANES];
    logic signed [SAMPLE_W-1:0] lane_in    [LANES];
    logic signed [23:0]         prod1_reg  [LANES];
    logic signed [23:0]         prod1_next [LANES];
    logic [23:0]                abs1       [LANES];
    logic                       neg_reg    [LANES];
    logic [37:0]                mag_reg    [LANES];
    logic [37:0]                mag_next   [LANES];
    logic [38:0]                round_sum  [LANES];
    logic [34:0]                scaled_reg [LANES];
    logic [34:0]                scaled_next[LANES];
    logic [46:0]                est_reg    [LANES];
    logic [46:0]                est_next   [LANES];
    logic [14:0]                qest_reg   [LANES];
    logic [14:0]                qest_next  [LANES];
    logic [35:0]                back_reg   [LANES];
    logic [35:0]                back_next  [LANES];
    logic [35:0]                remainder  [LANES];
    logic [15:0]                quot       [LANES];
    logic signed [15:0]         tap        [LANES];
    logic signed [16:0]         sum        [LANES];
    logic signed [SAMPLE_W-1:0] sat        [LANES];

    // Read index in frames; the delay's low bit is dropped by the frame view.
    assign rd_diff  = 32'(wp_reg) - 32'(delay_entries_reg[DELAY_W-1:1]);
    assign rd_frame = rd_diff[RING_FW-1:0];
    // Frames are written in order from zero, so anything at or past the write
    // pointer has never been written until the pointer has wrapped once.
    assign rd_hit   = wrapped_reg || (rd_frame < wp_reg);

    ssd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (FRAME_DEPTH)
    ) u_ram_left (
        .aclk    (aclk),
        .wr_en   (cmd.finish),
        .wr_addr (wp_reg),
        .wr_data (sat[0]),
        .rd_en   (cmd.accept),
        .rd_addr (rd_frame),
        .rd_data (ram_rdata[0])
    );

    ssd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (FRAME_DEPTH)
    ) u_ram_right (
        .aclk    (aclk),
        .wr_en   (cmd.finish),
        .wr_addr (wp_reg),
        .wr_data (sat[1]),
        .rd_en   (cmd.accept),
        .rd_addr (rd_frame),
        .rd_data (ram_rdata[1])
    );

    assign weight[0]  = PAN_SPAN - pan_count_reg;
    assign weight[1]  = pan_count_reg;
    assign lane_in[0] = in_left_reg;
    assign lane_in[1] = in_right_reg;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            tap_sample[i]  = hit_reg ? $signed(ram_rdata[i]) : '0;
            prod1_next[i]  = 24'(tap_sample[i]) * 24'(weight[i]);
            abs1[i]        = prod1_reg[i][23] ? 24'(-prod1_reg[i]) : 24'(prod1_reg[i]);
            mag_next[i]    = 38'(abs1[i][21:0]) * 38'(delay_gain_reg);
            round_sum[i]   = 39'(mag_reg[i]) + 39'(TAP_HALF);
            scaled_next[i] = round_sum[i][37:3];
            est_next[i]    = 47'(scaled_next[i][34:13]) * 47'(TAP_RECIP);
            qest_next[i]   = est_reg[i][46:32];
            back_next[i]   = 36'(qest_next[i]) * 36'(TAP_E);
            // The estimate is low by at most one; one compare settles it.
            remainder[i]   = 36'(scaled_reg[i]) - back_reg[i];
            quot[i]        = 16'(qest_reg[i]) + 16'(remainder[i] >= 36'(TAP_E));
            tap[i]         = neg_reg[i] ? -$signed(quot[i]) : $signed(quot[i]);
            sum[i]         = 17'(lane_in[i]) + 17'(tap[i]);
            if (sum[i] > 17'sd32767) begin
                sat[i] = 16'sh7fff;
            end else if (sum[i] < -17'sd32768) begin
                sat[i] = 16'sh8000;
            end else begin
                sat[i] = sum[i][15:0];
            end
        end
    end

    always_comb begin
        delay_entries_next = delay_entries_reg;
        delay_gain_next    = delay_gain_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_DELAY_ENTRIES: delay_entries_next = cfg_data[DELAY_W-1:0];
                CFG_DELAY_GAIN:    delay_gain_next    = cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        wp_next          = wp_reg;
        wrapped_next     = wrapped_reg;
        pan_count_next   = pan_count_reg;
        pan_falling_next = pan_falling_reg;
        if (cmd.finish) begin
            wp_next = wp_reg + 1'b1;
            if (wp_reg == '1) begin
                wrapped_next = 1'b1;
            end
            if (in_end_reg) begin
                // The sweep overshoots each end by one step before turning.
                if (!pan_falling_reg) begin
                    pan_count_next = pan_count_reg + 8'sd1;
                    if (pan_count_reg >= PAN_SPAN) begin
                        pan_falling_next = 1'b1;
                    end
                end else begin
                    pan_count_next = pan_count_reg - 8'sd1;
                    if (pan_count_reg <= 8'sd0) begin
                        pan_falling_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_entries_reg <= '0;
            delay_gain_reg    <= '0;
            wp_reg            <= '0;
            wrapped_reg       <= 1'b0;
            pan_count_reg     <= '0;
            pan_falling_reg   <= 1'b0;
        end else begin
            delay_entries_reg <= delay_entries_next;
            delay_gain_reg    <= delay_gain_next;
            wp_reg            <= wp_next;
            wrapped_reg       <= wrapped_next;
            pan_count_reg     <= pan_count_next;
            pan_falling_reg   <= pan_falling_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_left_reg  <= s_data.left_in;
            in_right_reg <= s_data.right_in;
            in_end_reg   <= s_data.block_end;
            hit_reg      <= rd_hit;
        end
        for (int i = 0; i < LANES; i++) begin
            if (cmd.stage1) begin
                prod1_reg[i] <= prod1_next[i];
            end
            if (cmd.stage2) begin
                mag_reg[i] <= mag_next[i];
                neg_reg[i] <= prod1_reg[i][23];
            end
            if (cmd.stage3) begin
                scaled_reg[i] <= scaled_next[i];
                est_reg[i]    <= est_next[i];
            end
            if (cmd.stage4) begin
                qest_reg[i] <= qest_next[i];
                back_reg[i] <= back_next[i];
            end
        end
        if (cmd.finish) begin
            out_reg.left_out  <= sat[0];
            out_reg.right_out <= sat[1];
        end
    end

    assign m_data = out_reg;

endmodule

// ===== hdl/stereo_sweep_delay_core.sv =====
// An accepted frame steps through MUL1 to MUL4 and DONE, which waits for a free
// output register. Frames are taken one at a time, paced by the multiply chain of
// the tap scaling, which one state machine steps through for each frame. A new
// frame is accepted while the previous result still waits on m_ready. Reset
// clears the state machine, write pointer, pan sweep and config registers; the
// ring is not swept: frames not yet written read as zero by pointer tracking.
`timescale 1ns / 1ps

module stereo_sweep_delay_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  ssd_pkg::in_t                    s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output ssd_pkg::out_t                   m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ssd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ssd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ssd_pkg::*;

    ctrl_cmd_t cmd;

    assign cfg_ready = 1'b1;

    ssd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    ssd_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_data    (m_data)
    );

    // The state machine issues at most one step per cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept, cmd.stage1, cmd.stage2, cmd.stage3, cmd.stage4, cmd.finish}))
        else $error("more than one datapath step issued in a cycle");

    // A finished frame never overwrites a result that has not been taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_valid || m_ready))
        else $error("result register overwritten before its transaction");

    // After a transaction is accepted, the input stays closed while it is worked.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a frame is in progress");

    // Each accepted frame runs through the multiply steps in order.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> cmd.stage1 ##1 cmd.stage2 ##1 cmd.stage3 ##1 cmd.stage4)
        else $error("tap steps out of order");

endmodule
